### rtl/gwd_pkg.sv
// Shared types and constants of the gRPC-Web deframer.
package gwd_pkg;

  localparam logic KindHeader = 1'b0;
  localparam logic KindBody   = 1'b1;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  localparam logic [3:0]  KeyLen     = 4'd12;
  localparam logic [7:0]  CharNl     = 8'h0A;
  localparam logic [7:0]  Char0      = 8'h30;
  localparam logic [7:0]  Char9      = 8'h39;
  localparam logic [30:0] StatusMax  = 31'h7FFF_FFFF;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [7:0]  flags;
    logic [31:0] length;
    logic        last;
  } op_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  out_byte;
    logic [7:0]  frame_flags;
    logic        is_compressed;
    logic        is_trailer;
    logic [31:0] body_length;
    logic        frame_last;
    logic        status_found;
    logic [30:0] status_value;
  } result_t;

  // Characters of "grpc-status:".
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h67;
      4'd1:    c = 8'h72;
      4'd2:    c = 8'h70;
      4'd3:    c = 8'h63;
      4'd4:    c = 8'h2D;
      4'd5:    c = 8'h73;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h61;
      4'd8:    c = 8'h74;
      4'd9:    c = 8'h75;
      4'd10:   c = 8'h73;
      4'd11:   c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### rtl/gwd_if.sv
// Valid/ready channel interfaces for the deframer input and result streams.
interface gwd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface gwd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  out_byte;
  logic [7:0]  frame_flags;
  logic        is_compressed;
  logic        is_trailer;
  logic [31:0] body_length;
  logic        frame_last;
  logic        status_found;
  logic [30:0] status_value;

  modport source (output valid, output kind, output out_byte, output frame_flags,
                  output is_compressed, output is_trailer, output body_length,
                  output frame_last, output status_found, output status_value,
                  input ready);
  modport sink   (input valid, input kind, input out_byte, input frame_flags,
                  input is_compressed, input is_trailer, input body_length,
                  input frame_last, input status_found, input status_value,
                  output ready);
endinterface

### rtl/gwd_front.sv
// Front end: classifies each full frame prefix and each body byte into a request.
module gwd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [7:0]    in_data_i,
  output logic          in_ready_o,
  input  logic          q_full_i,
  output logic          q_push_o,
  output gwd_pkg::op_t  q_op_o
);
  import gwd_pkg::*;

  localparam logic [2:0] PrefixFirst = 3'd0;
  localparam logic [2:0] PrefixLast  = 3'd4;

  logic [2:0]  prefix_q, prefix_d;
  logic [7:0]  flags_q, flags_d;
  logic [31:0] len_q, len_d;
  logic [31:0] left_q, left_d;
  logic        in_body_q, in_body_d;
  logic        acc;

  assign in_ready_o = !q_full_i;
  assign acc        = in_valid_i && !q_full_i;

  always_comb begin
    prefix_d  = prefix_q;
    flags_d   = flags_q;
    len_d     = len_q;
    left_d    = left_q;
    in_body_d = in_body_q;
    q_push_o  = 1'b0;
    q_op_o.kind = KindHeader;
    q_op_o.data = 8'h00;
    q_op_o.last = 1'b0;
    if (acc) begin
      if (in_body_q) begin
        q_push_o    = 1'b1;
        q_op_o.kind = KindBody;
        q_op_o.data = in_data_i;
        q_op_o.last = (left_q <= 32'd1);
        if (left_q <= 32'd1) begin
          in_body_d = 1'b0;
          left_d    = 32'd0;
        end else begin
          left_d = left_q - 32'd1;
        end
      end else if (prefix_q == PrefixFirst) begin
        flags_d  = in_data_i;
        len_d    = 32'd0;
        prefix_d = prefix_q + 3'd1;
      end else begin
        len_d = {len_q[23:0], in_data_i};
        if (prefix_q != PrefixLast) begin
          prefix_d = prefix_q + 3'd1;
        end else begin
          prefix_d    = PrefixFirst;
          q_push_o    = 1'b1;
          q_op_o.last = (len_d == 32'd0);
          if (len_d != 32'd0) begin
            in_body_d = 1'b1;
            left_d    = len_d;
          end
        end
      end
    end
    q_op_o.flags  = flags_d;
    q_op_o.length = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q  <= PrefixFirst;
      flags_q   <= 8'h00;
      len_q     <= 32'd0;
      left_q    <= 32'd0;
      in_body_q <= 1'b0;
    end else begin
      prefix_q  <= prefix_d;
      flags_q   <= flags_d;
      len_q     <= len_d;
      left_q    <= left_d;
      in_body_q <= in_body_d;
    end
  end

endmodule

### rtl/gwd_fifo.sv
// Two-entry request queue between front and back.
module gwd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gwd_pkg::op_t  push_op_i,
  input  logic          pop_i,
  output gwd_pkg::op_t  pop_op_o,
  output logic          full_o,
  output logic          empty_o
);
  import gwd_pkg::*;

  op_t              mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o   = (cnt_q == QCntW'(QDepth));
  assign empty_o  = (cnt_q == '0);
  assign pop_op_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### rtl/gwd_back.sv
// Back end: trailer status scan and the registered result stage.
module gwd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  gwd_pkg::op_t     q_op_i,
  output logic             q_pop_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output gwd_pkg::result_t result_o
);
  import gwd_pkg::*;

  typedef enum logic [3:0] {
    PhSearch = 4'b0001,
    PhKey    = 4'b0010,
    PhDigits = 4'b0100,
    PhClosed = 4'b1000
  } phase_e;

  localparam logic [3:0] KeyFound = 4'd1;

  phase_e      ph_q, ph_d;
  logic [3:0]  key_q, key_d;
  logic        line_q, line_d;
  logic [30:0] acc_q, acc_d;
  logic        out_valid_q;
  result_t     res_q, res_d;

  logic        trailer, digit, found;
  logic [3:0]  dval;
  logic [34:0] acc10;

  assign q_pop_o     = !q_empty_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  assign trailer = q_op_i.flags[7];
  assign digit   = (q_op_i.data >= Char0) && (q_op_i.data <= Char9);
  assign dval    = 4'(q_op_i.data - Char0);
  assign acc10   = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {31'd0, dval};

  always_comb begin
    ph_d   = ph_q;
    key_d  = key_q;
    line_d = line_q;
    acc_d  = acc_q;
    if (q_op_i.kind == KindHeader) begin
      // restart the scan for the new frame
      ph_d   = PhSearch;
      key_d  = 4'd0;
      line_d = 1'b1;
      acc_d  = 31'd0;
    end else if (trailer) begin
      case (ph_q)
        PhSearch: begin
          if (key_q != 4'd0 || line_q) begin
            if (key_q < KeyLen && q_op_i.data == key_char(key_q)) begin
              if (key_q == KeyLen - 4'd1) begin
                ph_d  = PhKey;
                key_d = 4'd0;
              end else begin
                key_d = key_q + 4'd1;
              end
            end else begin
              key_d = 4'd0;
            end
          end
          line_d = (q_op_i.data == CharNl);
        end
        PhKey: begin
          if (digit) begin
            acc_d = {27'd0, dval};
            ph_d  = PhDigits;
          end else begin
            ph_d  = PhClosed;
            key_d = 4'd0;
          end
        end
        PhDigits: begin
          if (digit) begin
            // saturate at the largest 31-bit value
            acc_d = (acc10[34:31] != 4'd0) ? StatusMax : acc10[30:0];
          end else begin
            ph_d  = PhClosed;
            key_d = KeyFound;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    found = (q_op_i.kind == KindBody) && trailer && q_op_i.last &&
            ((ph_d == PhDigits) || ((ph_d == PhClosed) && (key_d == KeyFound)));
    res_d.kind          = q_op_i.kind;
    res_d.out_byte      = (q_op_i.kind == KindBody) ? q_op_i.data : 8'h00;
    res_d.frame_flags   = q_op_i.flags;
    res_d.is_compressed = q_op_i.flags[0];
    res_d.is_trailer    = q_op_i.flags[7];
    res_d.body_length   = q_op_i.length;
    res_d.frame_last    = q_op_i.last;
    res_d.status_found  = found;
    res_d.status_value  = found ? acc_d : 31'd0;
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PhSearch;
      key_q       <= 4'd0;
      line_q      <= 1'b1;
      acc_q       <= 31'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        ph_q        <= ph_d;
        key_q       <= key_d;
        line_q      <= line_d;
        acc_q       <= acc_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

### rtl/grpc_web_deframer_with_status.sv
// gRPC-Web deframer top level: front classifier, request queue, status scanner.
// Throughput: one byte per cycle while the queue is not full, limited by the single-byte input port.
// Each accepted byte's request is written into the queue; the output register
// takes it once the output holds no result or its result is being taken; prefix
// bytes one to four give no result. Reset (asynchronous, active low) empties the
// queue and the output stage and returns the parser to the start of a frame
// prefix.
module grpc_web_deframer_with_status (
  input  logic      clk_i,
  input  logic      rst_ni,
  gwd_in_if.sink    in_i,
  gwd_out_if.source out_o
);
  import gwd_pkg::*;

  logic    q_push, q_pop, q_full, q_empty;
  op_t     push_op, pop_op;
  result_t res;

  gwd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_data_i  (in_i.data_byte),
    .in_ready_o (in_i.ready),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_op_o     (push_op)
  );

  gwd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_op_i (push_op),
    .pop_i     (q_pop),
    .pop_op_o  (pop_op),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  gwd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_op_i      (pop_op),
    .q_pop_o     (q_pop),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .result_o    (res)
  );

  assign out_o.kind          = res.kind;
  assign out_o.out_byte      = res.out_byte;
  assign out_o.frame_flags   = res.frame_flags;
  assign out_o.is_compressed = res.is_compressed;
  assign out_o.is_trailer    = res.is_trailer;
  assign out_o.body_length   = res.body_length;
  assign out_o.frame_last    = res.frame_last;
  assign out_o.status_found  = res.status_found;
  assign out_o.status_value  = res.status_value;

  a_hdr_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind == KindHeader) |->
      (out_o.frame_last == (out_o.body_length == 32'd0)))
    else $error("header last mark does not match body length");

  a_status_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status_found) |->
      (out_o.kind == KindBody && out_o.frame_last && out_o.is_trailer))
    else $error("status reported off the last trailer byte");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.status_found) |-> (out_o.status_value == 31'd0))
    else $error("status value set without status found");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_empty && !q_push) |=> !(q_pop && q_empty && !$past(q_push)) || !q_empty)
    else $error("request popped from an empty queue");

endmodule

### dv/tb_grpc_web_deframer_with_status.sv
// Self-checking testbench for the gRPC-Web deframer with trailer status extraction.
module tb_grpc_web_deframer_with_status;
  import gwd_pkg::*;

  localparam int QuietLimit = 5000;
  localparam int StreamBytes = 950;
  localparam int MaxReports = 20;

  typedef enum logic [1:0] {
    ScanSearch,
    ScanKeyDone,
    ScanDigits,
    ScanClosed
  } scan_e;

  class deframe_scoreboard;
    string       key_text = "grpc-status:";
    logic [2:0]  prefix_cnt;
    logic [7:0]  flags;
    logic [31:0] frame_len;
    logic [31:0] remaining;
    bit          in_body;
    logic [3:0]  key_pos;
    bit          line_start;
    scan_e       phase;
    logic [30:0] accum;
    result_t     pending_results[$];
    int          errors;
    int          checked;
    int          frames;
    int          trailers;
    int          statuses;

    function new();
      prefix_cnt = '0;
      flags      = '0;
      frame_len  = '0;
      remaining  = '0;
      in_body    = 1'b0;
      restart_scan();
    endfunction

    function void restart_scan();
      key_pos    = '0;
      line_start = 1'b1;
      phase      = ScanSearch;
      accum      = '0;
    endfunction

    function void scan_status(logic [7:0] b);
      bit          digit;
      logic [63:0] wide;
      digit = (b >= Char0) && (b <= Char9);
      case (phase)
        ScanSearch: begin
          // key may only start at the beginning of a line
          if (key_pos != 0 || line_start) begin
            if (key_pos < KeyLen && b == key_text[key_pos]) begin
              key_pos++;
              if (key_pos == KeyLen) begin
                phase   = ScanKeyDone;
                key_pos = '0;
              end
            end else begin
              key_pos = '0;
            end
          end
          line_start = (b == CharNl);
        end
        ScanKeyDone: begin
          if (digit) begin
            accum = {23'd0, b - Char0};
            phase = ScanDigits;
          end else begin
            phase   = ScanClosed;
            key_pos = '0;
          end
        end
        ScanDigits: begin
          if (digit) begin
            wide  = {33'd0, accum} * 64'd10 + {56'd0, b} - {56'd0, Char0};
            accum = (wide > {33'd0, StatusMax}) ? StatusMax : wide[30:0];
          end else begin
            phase   = ScanClosed;
            key_pos = 4'd1;
          end
        end
        default: ;
      endcase
    endfunction

    // Advance the predicted state by one accepted byte and queue its result, if any.
    function void note_byte(logic [7:0] b);
      result_t r;
      bit      last;
      r = '0;
      if (!in_body) begin
        if (prefix_cnt == 0) begin
          flags      = b;
          frame_len  = '0;
          prefix_cnt = 3'd1;
          return;
        end
        frame_len = {frame_len[23:0], b};
        if (prefix_cnt < 4) begin
          prefix_cnt++;
          return;
        end
        prefix_cnt = '0;
        restart_scan();
        frames++;
        if (flags[7]) trailers++;
        r.kind       = KindHeader;
        r.frame_last = (frame_len == 0);
        if (frame_len != 0) begin
          in_body   = 1'b1;
          remaining = frame_len;
        end
      end else begin
        last = (remaining <= 1);
        if (flags[7]) scan_status(b);
        r.kind       = KindBody;
        r.out_byte   = b;
        r.frame_last = last;
        if (last) begin
          if (flags[7]) begin
            r.status_found = (phase == ScanDigits) || (phase == ScanClosed && key_pos == 1);
          end
          if (r.status_found) statuses++;
          in_body   = 1'b0;
          remaining = '0;
        end else begin
          remaining--;
        end
      end
      r.frame_flags   = flags;
      r.is_compressed = flags[0];
      r.is_trailer    = flags[7];
      r.body_length   = frame_len;
      r.status_value  = r.status_found ? accum : '0;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("%0t: unexpected result, expected none, got %p", $time, got);
        end
        return;
      end
      want = pending_results.pop_front();
      checked++;
      compare_field("kind", 32'(want.kind), 32'(got.kind));
      compare_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
      compare_field("frame_flags", 32'(want.frame_flags), 32'(got.frame_flags));
      compare_field("is_compressed", 32'(want.is_compressed), 32'(got.is_compressed));
      compare_field("is_trailer", 32'(want.is_trailer), 32'(got.is_trailer));
      compare_field("body_length", want.body_length, got.body_length);
      compare_field("frame_last", 32'(want.frame_last), 32'(got.frame_last));
      compare_field("status_found", 32'(want.status_found), 32'(got.status_found));
      compare_field("status_value", 32'(want.status_value), 32'(got.status_value));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   calm;
  int   bytes_sent;
  logic [7:0] body_q[$];
  deframe_scoreboard sb;

  gwd_in_if  in_if ();
  gwd_out_if out_if ();

  grpc_web_deframer_with_status DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Mostly no gap, some short ones, a few long ones; none while calm.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
  endfunction

  function automatic void add_noise(int n);
    repeat (n) begin
      case ($urandom_range(0, 7))
        0:       body_q.push_back(8'($urandom));
        1:       body_q.push_back(CharNl);
        default: body_q.push_back(8'($urandom_range(32, 126)));
      endcase
    end
  endfunction

  function automatic void add_digits(int n);
    repeat (n) body_q.push_back(Char0 + 8'($urandom_range(0, 9)));
  endfunction

  // Build a trailer body: optional header lines, then mostly a status line of some shape.
  function automatic void compose_trailer();
    body_q.delete();
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0: add_text("grpc-message: ok");
        1: add_text("grpc-sta");
        2: add_text(" grpc-status:3");
        default: add_noise($urandom_range(1, 6));
      endcase
      if ($urandom_range(0, 1)) body_q.push_back(8'h0D);
      body_q.push_back(CharNl);
    end
    if ($urandom_range(0, 9) != 0) begin
      add_text("grpc-status:");
      case ($urandom_range(0, 9))
        0: ;
        1: add_text(" 7");
        2: add_digits($urandom_range(10, 13));
        3: add_text($urandom_range(0, 1) ? "2147483647" : "2147483648");
        default: add_digits($urandom_range(1, 3));
      endcase
      if ($urandom_range(0, 1)) begin
        add_text("\r\n");
        if ($urandom_range(0, 1)) add_text("grpc-status:5");
        else add_noise($urandom_range(0, 8));
      end
    end
  endfunction

  function automatic void compose_data();
    body_q.delete();
    if ($urandom_range(0, 4) == 0) add_text("grpc-status:1\n");
    add_noise(($urandom_range(0, 5) == 0) ? $urandom_range(0, 48) : $urandom_range(0, 16));
  endfunction

  task automatic push_byte(input logic [7:0] b);
    repeat (pick_gap()) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] frame_flags, input logic [31:0] len);
    push_byte(frame_flags);
    push_byte(len[31:24]);
    push_byte(len[23:16]);
    push_byte(len[15:8]);
    push_byte(len[7:0]);
    foreach (body_q[i]) push_byte(body_q[i]);
  endtask

  initial begin : result_sink
    int stall;
    stall        = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        sb.check_result({out_if.kind, out_if.out_byte, out_if.frame_flags, out_if.is_compressed,
                         out_if.is_trailer, out_if.body_length, out_if.frame_last,
                         out_if.status_found, out_if.status_value});
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 4) == 0) stall = pick_gap();
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no request accepted for %0d cycles", $time, QuietLimit);
    $display("grpc_web_deframer_with_status verification failed");
    $finish;
  end

  initial begin : stimulus
    int pick;
    sb              = new();
    calm            = 1'b0;
    bytes_sent      = 0;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = 8'h00;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero-length trailer with the compressed bit, then a body that ends on the key.
    body_q.delete();
    send_frame(8'h81, 32'd0);
    add_text("grpc-status:");
    send_frame(8'h80, body_q.size());

    while (bytes_sent < StreamBytes) begin
      calm = ($urandom_range(0, 5) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        compose_trailer();
        send_frame({1'b1, 7'($urandom)}, body_q.size());
      end else if (pick == 4) begin
        body_q.delete();
        send_frame(8'($urandom), 32'd0);
      end else begin
        compose_data();
        send_frame({1'b0, 7'($urandom)}, body_q.size());
      end
    end

    // Maximum length: the frame never completes, so only its first bytes are checked.
    calm = 1'b0;
    body_q.delete();
    add_text("grpc-status:42\n");
    send_frame({1'b1, 7'($urandom)}, 32'hFFFF_FFFF);
    in_if.valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (sb.pending_results.size() != 0) begin
      sb.errors += sb.pending_results.size();
      $display("%0t: %0d expected results never arrived", $time, sb.pending_results.size());
    end

    $display("Sent %0d stream bytes in %0d frames, %0d of them trailers (%0d carried a status).",
             bytes_sent, sb.frames, sb.trailers, sb.statuses);
    $display("Checked %0d results, %0d field mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("grpc_web_deframer_with_status verification clean");
    end else begin
      $display("grpc_web_deframer_with_status verification failed");
    end
    $finish;
  end

endmodule
